// File: src/dahdsr_pkg.sv
// ----------------------------------------------------------------------------
// dahdsr_pkg
// Shared widths, stage codes and register indexes of the envelope generator.
// ----------------------------------------------------------------------------
package dahdsr_pkg;
  localparam int unsigned LVL_W = 16;
  localparam int unsigned STG_W = 3;
  localparam int unsigned FULL_SCALE = 32768;
  localparam int unsigned LOG10_2_Q4 = 4932;

  localparam logic [STG_W-1:0] STG_DELAY   = 3'd0;
  localparam logic [STG_W-1:0] STG_ATTACK  = 3'd1;
  localparam logic [STG_W-1:0] STG_HOLD    = 3'd2;
  localparam logic [STG_W-1:0] STG_DECAY   = 3'd3;
  localparam logic [STG_W-1:0] STG_SUSTAIN = 3'd4;
  localparam logic [STG_W-1:0] STG_RELEASE = 3'd5;
  localparam logic [STG_W-1:0] STG_IDLE    = 3'd6;

  localparam logic [2:0] REG_DELAY   = 3'd0;
  localparam logic [2:0] REG_ATTACK  = 3'd1;
  localparam logic [2:0] REG_HOLD    = 3'd2;
  localparam logic [2:0] REG_DECAY   = 3'd3;
  localparam logic [2:0] REG_SUSTAIN = 3'd4;
  localparam logic [2:0] REG_RELEASE = 3'd5;
  localparam logic [2:0] REG_LOOPED  = 3'd6;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [STG_W-1:0] stage;
    logic             last;
  } out_word_t;

  // Truncated Q16 log2, as used to build the release penalty table.
  function automatic logic [31:0] log2_q16(input logic [31:0] m);
    logic [63:0] y;
    logic [31:0] r;
    int unsigned n;
    n = 0;
    y = 0;
    r = 0;
    if (m != 0) begin
      for (int i = 0; i < 32; i++) if ((m >> i) != 0) n = i;
      y = 64'(m) << (30 - n);
      r = 32'(n) << 16;
      for (int b = 15; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= 64'h8000_0000) begin
          y = y >> 1;
          r[b] = 1'b1;
        end
      end
    end
    return r;
  endfunction
endpackage

// File: src/dahdsr_if.sv
// ----------------------------------------------------------------------------
// dahdsr_in_if / dahdsr_out_if
// Valid/ready channels of the envelope generator.
// ----------------------------------------------------------------------------
interface dahdsr_in_if #(parameter int FRAME_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [FRAME_BITS-1:0] note_frames;
  modport source (output valid, op, note_frames, input ready);
  modport sink   (input valid, op, note_frames, output ready);
endinterface

interface dahdsr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;
  logic [2:0]  stage;
  logic        last;
  modport source (output valid, level, stage, last, input ready);
  modport sink   (input valid, level, stage, last, output ready);
endinterface

// File: src/dahdsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// dahdsr_envelope_generator
// Delay/attack/hold/decay/sustain/release envelope, one gain word per tick.
// ----------------------------------------------------------------------------
// A note start word first runs the stage split. When the note ends inside
// the attack or the decay, the shared restoring divider then scales the
// level. The level update after a division, the penalty table read, the
// penalty multiply and the total length follow. A tick word on a ramp runs
// a locate pass, a multiply, a division and a load of the output register.
// Ticks on flat stages skip the multiply and the division, and a tick while
// idle goes from the locate state straight to the output register. A word
// still waiting at the output holds the next tick before its load. The block
// takes one word at a time. After reset a table build pass fills the penalty
// table before any word is taken. Each entry gets a normalize step, repeated
// squaring for the log2 fraction and a write step. Configuration writes are
// accepted during this pass.
module dahdsr_envelope_generator #(
  parameter int FRAME_BITS = 24,
  parameter int PENALTY_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [FRAME_BITS-1:0] cfg_wdata,
  dahdsr_in_if.sink             in_ch,
  dahdsr_out_if.source          out_ch
);
  import dahdsr_pkg::*;

  localparam int FB  = FRAME_BITS;
  localparam int PB  = FB + 3;
  localparam int DW  = FB + 17;
  localparam int TAW = $clog2(PENALTY_TABLE_DEPTH);
  localparam int CW  = $clog2(DW + 1);

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_SPLIT = 4'd2,
    S_LVL = 4'd3, S_PENRD = 4'd4, S_PENMUL = 4'd5, S_DIV = 4'd6,
    S_TICK = 4'd7, S_RAMP = 4'd8, S_EMIT = 4'd9, S_OUT = 4'd10;

  localparam logic [1:0] IP_NORM = 2'd0, IP_SQR = 2'd1, IP_WR = 2'd2;
  localparam logic [31:0] TAB_TOP = log2_q16(32'(PENALTY_TABLE_DEPTH));

  logic [FB-1:0] dly_r, att_r, hld_r, dec_r, rel_r;
  logic [15:0]   sus_r;
  logic          loop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r <= '0; att_r <= '0; hld_r <= '0; dec_r <= '0; rel_r <= '0;
      sus_r <= '0; loop_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY:   dly_r  <= cfg_wdata;
        REG_ATTACK:  att_r  <= cfg_wdata;
        REG_HOLD:    hld_r  <= cfg_wdata;
        REG_DECAY:   dec_r  <= cfg_wdata;
        REG_SUSTAIN: sus_r  <= cfg_wdata[15:0];
        REG_RELEASE: rel_r  <= cfg_wdata;
        REG_LOOPED:  loop_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Penalty table, filled by a sweep after reset.
  logic [TAW-1:0] tab_addr_r, tab_addr_nxt;
  logic [15:0]    tab_rd;
  logic           tab_we;
  logic [15:0]    tab_wd;
  logic [31:0]    tab_diff;
  logic [47:0]    tab_prod;
  logic [1:0]     ip_r, ip_nxt;
  logic [31:0]    iy_r, iy_nxt, ir_r, ir_nxt;
  logic [3:0]     ib_r, ib_nxt;
  logic [31:0]    im;
  logic [4:0]     msb;
  logic [63:0]    isq;

  assign im = 32'(PENALTY_TABLE_DEPTH) - 32'(tab_addr_r);
  assign isq = {32'd0, iy_r} * {32'd0, iy_r};
  assign tab_diff = TAB_TOP - ir_r;
  assign tab_prod = 48'(tab_diff) * 48'(LOG10_2_Q4);
  assign tab_wd = tab_prod[31:16];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) if (im[i]) msb = 5'(i);
  end

  dahdsr_ram #(.WIDTH(16), .DEPTH(PENALTY_TABLE_DEPTH)) u_pen (
    .clk(clk), .we(tab_we), .waddr(tab_addr_r), .wdata(tab_wd),
    .raddr(tab_addr_nxt), .rdata(tab_rd)
  );

  logic [3:0]      st_r, st_nxt, ret_r, ret_nxt;
  logic [FB-1:0]   len_r [6];
  logic [FB-1:0]   len_nxt [6];
  logic [15:0]     peak_r, peak_nxt, rls_r, rls_nxt, shd_r, shd_nxt, sc_r, sc_nxt;
  logic [FB:0]     pos_r, pos_nxt, tot_r, tot_nxt;
  logic            act_r, act_nxt;
  logic [FB-1:0]   rem_r, rem_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [FB:0]     off_r, off_nxt;
  logic [1:0]      lk_r, lk_nxt;
  out_word_t       ow_r, ow_nxt;
  // Word under construction; the output register only takes it when free.
  out_word_t       wk_r, wk_nxt;
  logic            ov_r, ov_nxt;
  // Shared restoring divider: quotient num/den, one bit per cycle.
  logic [DW-1:0]   dn_r, dn_nxt, dq_r, dq_nxt;
  logic [DW-1:0]   dd_r, dd_nxt, drm_r, drm_nxt;
  logic [CW-1:0]   dc_r, dc_nxt;
  logic            neg_r, neg_nxt;
  logic [DW:0]     trial;
  logic [FB+16:0]  prod;
  logic [15:0]     mul_a;
  logic [FB:0]     mul_b;

  assign trial = {drm_r, dn_r[DW-1]} - {1'b0, dd_r};

  // One shared multiplier serves the penalty and ramp products.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      S_PENMUL: begin mul_a = tab_rd; mul_b = {1'b0, rel_r}; end
      S_RAMP:   begin mul_a = sc_r; mul_b = off_r; end
      default: ;
    endcase
  end
  assign prod = (FB+17)'(mul_a) * (FB+17)'(mul_b);

  always_comb begin
    logic [FB+1:0] lim;
    logic [FB-1:0] cur;
    logic [DW-1:0] q;
    logic [15:0]   s;
    logic [16:0]   lv;
    st_nxt = st_r; ret_nxt = ret_r;
    for (int i = 0; i < 6; i++) len_nxt[i] = len_r[i];
    peak_nxt = peak_r; rls_nxt = rls_r; shd_nxt = shd_r; sc_nxt = sc_r;
    pos_nxt = pos_r; tot_nxt = tot_r; act_nxt = act_r; rem_nxt = rem_r;
    k_nxt = k_r; off_nxt = off_r; lk_nxt = lk_r; ow_nxt = ow_r; ov_nxt = ov_r;
    wk_nxt = wk_r;
    dn_nxt = dn_r; dq_nxt = dq_r; dd_nxt = dd_r; drm_nxt = drm_r;
    dc_nxt = dc_r; neg_nxt = neg_r;
    tab_we = 1'b0; tab_addr_nxt = tab_addr_r;
    ip_nxt = ip_r; iy_nxt = iy_r; ir_nxt = ir_r; ib_nxt = ib_r;
    s = (sus_r > 16'(FULL_SCALE)) ? 16'(FULL_SCALE) : sus_r;
    lim = (FB+2)'(dly_r) + (FB+2)'(att_r) + (FB+2)'(hld_r) + 1'b1;
    cur = dly_r;
    case (k_r)
      3'd0: cur = dly_r;
      3'd1: cur = att_r;
      3'd2: cur = hld_r;
      3'd3: cur = dec_r;
      default: cur = dly_r;
    endcase
    q = dq_r;
    lv = '0;
    if (out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      S_INIT: begin
        case (ip_r)
          IP_NORM: begin
            iy_nxt = im << (5'd30 - msb);
            ir_nxt = {11'd0, msb, 16'd0};
            ib_nxt = 4'd15;
            ip_nxt = IP_SQR;
          end
          IP_SQR: begin
            if (isq[61]) begin
              iy_nxt = isq[62:31]; ir_nxt[{1'b0, ib_r}] = 1'b1;
            end else begin
              iy_nxt = isq[61:30];
            end
            ib_nxt = ib_r - 1'b1;
            if (ib_r == 4'd0) ip_nxt = IP_WR;
          end
          default: begin
            tab_we = 1'b1;
            tab_addr_nxt = tab_addr_r + 1'b1;
            ip_nxt = IP_NORM;
            if (32'(tab_addr_r) == 32'(PENALTY_TABLE_DEPTH - 1)) st_nxt = S_IDLE;
          end
        endcase
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          if (!in_ch.op) begin
            rem_nxt = in_ch.note_frames;
            if (!loop_r && s != 0 && (FB+2)'(in_ch.note_frames) > lim)
              rem_nxt = lim[FB-1:0];
            for (int i = 0; i < 6; i++) len_nxt[i] = '0;
            peak_nxt = 16'(FULL_SCALE); shd_nxt = s; rls_nxt = '0;
            lk_nxt = 2'd0; k_nxt = 3'd0; st_nxt = S_SPLIT;
          end else st_nxt = S_TICK;
        end
      end
      S_SPLIT: begin
        // One stage per cycle; a stage the note ends in closes the split.
        if (k_r == 3'd4) begin
          len_nxt[4] = rem_r; rls_nxt = s; st_nxt = S_PENRD;
        end else if (rem_r <= cur) begin
          len_nxt[k_r] = rem_r;
          case (k_r)
            3'd1: begin
              lk_nxt = 2'd1; st_nxt = S_DIV; ret_nxt = S_LVL;
              dn_nxt = DW'({rem_r, 15'd0}); dd_nxt = DW'(att_r);
              dq_nxt = '0; drm_nxt = '0; dc_nxt = CW'(DW);
            end
            3'd2: begin rls_nxt = 16'(FULL_SCALE); st_nxt = S_PENRD; end
            3'd3: begin
              lk_nxt = 2'd2; st_nxt = S_DIV; ret_nxt = S_LVL;
              dn_nxt = DW'(17'(FULL_SCALE - 32'(s)) * (FB+17)'(rem_r));
              dd_nxt = DW'(dec_r); dq_nxt = '0; drm_nxt = '0; dc_nxt = CW'(DW);
            end
            default: st_nxt = S_PENRD;
          endcase
        end else begin
          len_nxt[k_r] = cur; rem_nxt = rem_r - cur; k_nxt = k_r + 1'b1;
        end
      end
      S_LVL: begin
        if (lk_r == 2'd1) begin
          peak_nxt = dq_r[15:0]; rls_nxt = dq_r[15:0];
        end else begin
          rls_nxt = 16'(FULL_SCALE - 32'(dq_r[15:0]));
          shd_nxt = 16'(FULL_SCALE - 32'(dq_r[15:0]));
        end
        st_nxt = S_PENRD;
      end
      S_PENRD: begin
        tab_addr_nxt = TAW'((32'(rls_r) * 32'(PENALTY_TABLE_DEPTH)) >> 15);
        st_nxt = S_PENMUL;
      end
      S_PENMUL: begin
        len_nxt[5] = rel_r;
        if (rls_r != 0 && rls_r < 16'(FULL_SCALE)) len_nxt[5] = prod[FB+15:16];
        tot_nxt = '0;
        st_nxt = S_EMIT;
        ret_nxt = S_IDLE;
      end
      S_EMIT: begin
        // Note start tail: total length, then back to idle.
        tot_nxt = (FB+1)'(len_r[0]) + (FB+1)'(len_r[1]) + (FB+1)'(len_r[2])
                + (FB+1)'(len_r[3]) + (FB+1)'(len_r[4]) + (FB+1)'(len_r[5]);
        pos_nxt = '0;
        act_nxt = tot_nxt != 0;
        st_nxt = S_IDLE;
      end
      S_TICK: begin
        // Locate the stage of the current frame, one stage per cycle.
        if (!act_r) begin
          wk_nxt = '{level: '0, stage: STG_IDLE, last: 1'b0};
          st_nxt = S_OUT;
        end else if (k_r == 3'd0 && off_r == pos_r && lk_r == 2'd3) begin
          st_nxt = S_TICK;
        end else begin
          st_nxt = S_TICK;
        end
        if (act_r) begin
          if (lk_r != 2'd3) begin
            k_nxt = 3'd0; off_nxt = pos_r; lk_nxt = 2'd3;
          end else if (off_r < (FB+1)'(len_r[k_r])) begin
            wk_nxt.stage = k_r;
            wk_nxt.last = (pos_r + 1'b1) == tot_r;
            case (k_r)
              3'd0: begin wk_nxt.level = '0; st_nxt = S_OUT; end
              3'd2: begin wk_nxt.level = peak_r; st_nxt = S_OUT; end
              3'd4: begin wk_nxt.level = shd_r; st_nxt = S_OUT; end
              default: begin
                if (len_r[k_r] <= 1) begin
                  wk_nxt.level = (k_r == 3'd1) ? peak_r : (k_r == 3'd3) ? shd_r : '0;
                  st_nxt = S_OUT;
                end else begin
                  if (k_r == 3'd1) begin sc_nxt = peak_r; neg_nxt = 1'b0; end
                  else if (k_r == 3'd3) begin
                    neg_nxt = shd_r < peak_r;
                    sc_nxt = neg_nxt ? peak_r - shd_r : shd_r - peak_r;
                  end else begin sc_nxt = rls_r; neg_nxt = 1'b1; end
                  st_nxt = S_RAMP;
                end
              end
            endcase
          end else begin
            off_nxt = off_r - (FB+1)'(len_r[k_r]);
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_RAMP: begin
        dn_nxt = DW'(prod); dd_nxt = DW'(len_r[k_r] - 1'b1);
        dq_nxt = '0; drm_nxt = '0; dc_nxt = CW'(DW);
        st_nxt = S_DIV; ret_nxt = S_OUT; lk_nxt = 2'd0;
      end
      S_DIV: begin
        if (!trial[DW]) begin
          drm_nxt = trial[DW-1:0]; dq_nxt = {dq_r[DW-2:0], 1'b1};
        end else begin
          drm_nxt = {drm_r[DW-2:0], dn_r[DW-1]}; dq_nxt = {dq_r[DW-2:0], 1'b0};
        end
        dn_nxt = {dn_r[DW-2:0], 1'b0};
        dc_nxt = dc_r - 1'b1;
        if (dc_r == 1) begin
          if (ret_r == S_OUT) begin
            q = dq_nxt;
            case (wk_r.stage)
              STG_ATTACK: lv = 17'(q[15:0]);
              STG_DECAY:  lv = neg_r ? 17'(peak_r) - 17'(q[15:0])
                                     : 17'(peak_r) + 17'(q[15:0]);
              default:    lv = 17'(rls_r) - 17'(q[15:0]);
            endcase
            wk_nxt.level = lv[15:0];
          end
          st_nxt = ret_r;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ow_nxt = wk_r;
          if (act_r) begin
            pos_nxt = pos_r + 1'b1;
            if (pos_nxt >= tot_r) act_nxt = 1'b0;
          end
          lk_nxt = 2'd0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; ret_r <= S_IDLE; tab_addr_r <= '0; ip_r <= IP_NORM;
      act_r <= 1'b0; ov_r <= 1'b0; pos_r <= '0; tot_r <= '0;
      peak_r <= 16'(FULL_SCALE); rls_r <= '0; shd_r <= '0;
      for (int i = 0; i < 6; i++) len_r[i] <= '0;
      lk_r <= '0; k_r <= '0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; tab_addr_r <= tab_addr_nxt; ip_r <= ip_nxt;
      act_r <= act_nxt; ov_r <= ov_nxt; pos_r <= pos_nxt; tot_r <= tot_nxt;
      peak_r <= peak_nxt; rls_r <= rls_nxt; shd_r <= shd_nxt;
      for (int i = 0; i < 6; i++) len_r[i] <= len_nxt[i];
      lk_r <= lk_nxt; k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r <= sc_nxt; rem_r <= rem_nxt; off_r <= off_nxt; ow_r <= ow_nxt;
    wk_r <= wk_nxt;
    dn_r <= dn_nxt; dq_r <= dq_nxt; dd_r <= dd_nxt; drm_r <= drm_nxt;
    dc_r <= dc_nxt; neg_r <= neg_nxt;
    iy_r <= iy_nxt; ir_r <= ir_nxt; ib_r <= ib_nxt;
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.level = ow_r.level;
  assign out_ch.stage = ow_r.stage;
  assign out_ch.last  = ow_r.last;
endmodule

// File: src/dahdsr_ram.sv
// ----------------------------------------------------------------------------
// dahdsr_ram
// Simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module dahdsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: tb/dahdsr_envelope_generator_tb.sv
// ----------------------------------------------------------------------------
// dahdsr_envelope_generator_tb
// Drives note starts and frame ticks with random idling on both channels and
// checks every gain word against a cycle-free model of the envelope.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dahdsr_envelope_generator_tb;
  import dahdsr_pkg::*;

  localparam int FB = 24;
  localparam int PTD = 256;
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Envelope model and queue of expected gain words.
  class envelope_scoreboard;
    longint unsigned regs[7];
    longint unsigned seg_len[6];
    longint unsigned pos, peak, rel_lvl, sus;
    bit active;
    longint unsigned pen[PTD];
    out_word_t pending[$];
    int errors;

    function longint unsigned lg2(longint unsigned m);
      int unsigned n;
      longint unsigned y, r;
      n = 0;
      if (m == 0) return 0;
      while (n < 40 && (m >> (n + 1)) != 0) n++;
      y = m << (30 - n);
      r = longint'(n) << 16;
      for (int b = 15; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          r |= 64'd1 << b;
        end
      end
      return r;
    endfunction

    function new();
      longint unsigned top;
      top = lg2(PTD);
      for (int i = 0; i < PTD; i++) pen[i] = ((top - lg2(PTD - i)) * LOG10_2_Q4) >> 16;
      foreach (regs[i]) regs[i] = 0;
      foreach (seg_len[i]) seg_len[i] = 0;
      pos = 0; peak = FULL_SCALE; rel_lvl = 0; sus = 0; active = 0; errors = 0;
    endfunction

    function void write_reg(int idx, longint unsigned v);
      if (idx == REG_SUSTAIN) regs[idx] = v & 16'hFFFF;
      else if (idx == REG_LOOPED) regs[idx] = v & 1;
      else regs[idx] = v & 24'hFFFFFF;
    endfunction

    function longint unsigned ramp(longint a, longint b, longint i, longint n);
      if (n <= 1) return b;
      return a + ((b - a) * i) / (n - 1);
    endfunction

    function void start_note(longint unsigned nf);
      longint unsigned d, a, h, dc, s, r, dur, rem, rl, total;
      d = regs[0]; a = regs[1]; h = regs[2]; dc = regs[3];
      s = regs[4] > FULL_SCALE ? FULL_SCALE : regs[4];
      r = regs[5]; dur = nf; rl = 0; total = 0;
      if (regs[6] == 0 && s != 0 && dur > d + a + h + 1) dur = d + a + h + 1;
      foreach (seg_len[k]) seg_len[k] = 0;
      peak = FULL_SCALE; sus = s; rem = dur;
      if (rem <= d) seg_len[0] = rem;
      else begin
        seg_len[0] = d; rem -= d;
        if (rem <= a) begin
          peak = rem * FULL_SCALE / a; rl = peak; seg_len[1] = rem;
        end else begin
          seg_len[1] = a; rem -= a;
          if (rem <= h) begin
            rl = FULL_SCALE; seg_len[2] = rem;
          end else begin
            seg_len[2] = h; rem -= h;
            if (rem <= dc) begin
              rl = FULL_SCALE - (FULL_SCALE - s) * rem / dc;
              sus = rl; seg_len[3] = rem;
            end else begin
              seg_len[3] = dc; rem -= dc; rl = s; seg_len[4] = rem;
            end
          end
        end
      end
      if (rl > 0 && rl < FULL_SCALE) begin
        longint unsigned ix;
        ix = (rl * PTD) >> 15;
        if (ix >= PTD) ix = PTD - 1;
        r = (r * pen[ix]) >> 16;
      end
      seg_len[5] = r; rel_lvl = rl;
      foreach (seg_len[k]) total += seg_len[k];
      pos = 0; active = total != 0;
    endfunction

    function void note_input(logic op, logic [FB-1:0] nf);
      out_word_t w;
      longint unsigned total, p, n;
      int k;
      if (op == OP_START) begin
        start_note(nf);
        return;
      end
      w.level = 0; w.stage = STG_IDLE; w.last = 0;
      if (active) begin
        total = 0;
        foreach (seg_len[j]) total += seg_len[j];
        p = pos;
        for (k = 0; k < 6; k++) begin
          if (p < seg_len[k]) break;
          p -= seg_len[k];
        end
        if (k < 6) begin
          n = seg_len[k];
          w.stage = k[2:0];
          case (k)
            1: w.level = 16'(ramp(0, peak, p, n));
            2: w.level = 16'(peak);
            3: w.level = 16'(ramp(peak, sus, p, n));
            4: w.level = 16'(sus);
            5: w.level = 16'(ramp(rel_lvl, 0, p, n));
            default: w.level = 0;
          endcase
          w.last = (pos + 1 == total);
        end
        pos++;
        if (pos >= total) active = 0;
      end
      pending.push_back(w);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected word: level %0d stage %0d last %0d",
               got.level, got.stage, got.last);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.level !== exp_w.level) begin
        $error("level: expected %0d, got %0d", exp_w.level, got.level); errors++;
      end
      if (got.stage !== exp_w.stage) begin
        $error("stage: expected %0d, got %0d", exp_w.stage, got.stage); errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [FB-1:0] cfg_wdata = 0;
  bit quiet = 0;

  dahdsr_in_if #(.FRAME_BITS(FB)) in_ch();
  dahdsr_out_if out_ch();

  dahdsr_envelope_generator #(.FRAME_BITS(FB), .PENALTY_TABLE_DEPTH(PTD)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  envelope_scoreboard sb = new();

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 0; in_ch.op = 0; in_ch.note_frames = 0;
    out_ch.ready = 0;
  end

  // Result side: random stall bursts, then check on the accepting edge.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.level, out_ch.stage, out_ch.last});
  end

  // Valid stays high after a word so that the next one can follow at once.
  task automatic send_word(logic op, logic [FB-1:0] nf);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.op <= op; in_ch.note_frames <= nf;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, nf);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [FB-1:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_regs(logic [FB-1:0] d, a, h, dc, logic [15:0] s, logic [FB-1:0] r,
                          logic lp);
    drain();
    write_reg(REG_DELAY, d); write_reg(REG_ATTACK, a); write_reg(REG_HOLD, h);
    write_reg(REG_DECAY, dc); write_reg(REG_SUSTAIN, s); write_reg(REG_RELEASE, r);
    write_reg(REG_LOOPED, lp);
    cfg_we <= 0;
  endtask

  // A note start followed by enough ticks to play it out, or cut short.
  task automatic play(logic [FB-1:0] nf, int ticks);
    send_word(OP_START, nf);
    repeat (ticks) send_word(OP_TICK, FB'($urandom));
  endtask

  function automatic logic [FB-1:0] rnd_len();
    return ($urandom_range(0, 15) == 0) ? FB'($urandom) : FB'($urandom_range(0, 6));
  endfunction

  initial begin
    int sent;
    int next_prog;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed part.
    send_word(OP_TICK, 0);                       // tick while idle
    play(5, 2);                                  // zero registers put the whole note in sustain at level zero
    set_regs(2, 3, 2, 3, 16'd16384, 4, 0);
    play(24'hFFFFFF, 16);                        // duration cut, unlooped
    set_regs(2, 4, 1, 3, 16'd20000, 6, 1);
    play(1, 4);                                  // note ends in delay
    play(4, 8);                                  // truncated attack
    play(7, 8);                                  // truncated hold
    play(9, 12);                                 // truncated decay
    play(14, 3);                                 // restart while playing
    play(14, 20);
    set_regs(1, 1, 0, 1, 16'hFFFF, 3, 0);        // sustain above full scale
    play(6, 8);
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd32768, 24'hFFFFFF, 1);
    play(2, 3);
    set_regs(0, 0, 0, 0, 0, 0, 0);
    sent = 0;
    next_prog = 0;
    while (sent < 1150) begin
      if (sent >= next_prog) begin
        set_regs(rnd_len(), rnd_len(), rnd_len(), rnd_len(),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
                 ($urandom_range(0, 7) == 0) ? FB'($urandom) : FB'($urandom_range(0, 12)),
                 1'($urandom_range(0, 1)));
        next_prog += 100;
      end
      if (sent > 1000) quiet = 1;
      if ($urandom_range(0, 9) == 0) begin
        send_word(1'($urandom_range(0, 1)), FB'($urandom));
        sent++;
      end else begin
        int t;
        t = $urandom_range(1, 30);
        play(($urandom_range(0, 9) == 0) ? FB'($urandom) : FB'($urandom_range(0, 30)), t);
        sent += t + 1;
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
